// ===== rtl/rar_pkg.sv =====
// rar_pkg: shared types and constants for the rational arithmetic reducer.
// Operation codes, state encodings, queue flags and default sizes.
// No dependencies.
`default_nettype none

package rar_pkg;

   localparam int DEFAULT_OPERAND_BITS = 16;
   localparam int NUM_BITS             = 33;
   localparam int DEN_BITS             = 31;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   typedef enum logic [2:0] {
      F_IDLE,
      F_NUM,
      F_DEN,
      F_CROSS,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_STRIP,
      B_GCD,
      B_DIV,
      B_DONE
   } back_state_type;

   // classification of one queued transaction
   typedef struct packed {
      logic err;   // formed denominator is zero
      logic zero;  // formed numerator is zero
      logic neg;   // result is negative
   } q_flags_type;

endpackage

`default_nettype wire

// ===== rtl/rational_arith_reduce.sv =====
// Front: one state per product on the shared multiplier, plus a sum state for
// add/subtract, then a push into the queue. Back: a strip and binary-GCD loop,
// then bit-serial division of both terms by the GCD; error and zero results
// skip the GCD loop and the dividers.
// Reset (synchronous, active high) empties the queue and idles both engines.
`default_nettype none

module rational_arith_reduce import rar_pkg::*; #(
   parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [NUM_BITS-1:0]     rsp_res_num,
   output logic [DEN_BITS-1:0]            rsp_res_den,
   output logic                           rsp_zero_den_error
);

   localparam int MW = 2 * OPERAND_BITS + 1;
   localparam int DW = 2 * OPERAND_BITS;
   localparam int FW = $bits(q_flags_type);
   localparam int QW = FW + MW + DW;

   // front -> queue
   logic           push_valid, push_full;
   q_flags_type    push_flags;
   logic [MW-1:0]  push_nmag;
   logic [DW-1:0]  push_dmag;

   // queue -> back
   logic           pop_valid, pop;
   logic [QW-1:0]  pop_data;
   q_flags_type    pop_flags;
   logic [MW-1:0]  pop_nmag;
   logic [DW-1:0]  pop_dmag;

   // Front: takes one transaction at a time, forms the raw fraction in sign-magnitude.
   rar_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_a_num  (req_a_num),
      .req_a_den  (req_a_den),
      .req_b_num  (req_b_num),
      .req_b_den  (req_b_den),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_flags (push_flags),
      .push_nmag  (push_nmag),
      .push_dmag  (push_dmag)
   );

   // Queue decouples product formation from the long reduction.
   rar_queue #(.WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_full  (push_full),
      .wr_data  ({push_flags, push_nmag, push_dmag}),
      .rd_valid (pop_valid),
      .rd_pop   (pop),
      .rd_data  (pop_data)
   );

   assign pop_flags = pop_data[QW-1 -: FW];
   assign pop_nmag  = pop_data[DW +: MW];
   assign pop_dmag  = pop_data[DW-1:0];

   // Back: GCD reduction and the output register.
   rar_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop                (pop),
      .pop_flags          (pop_flags),
      .pop_nmag           (pop_nmag),
      .pop_dmag           (pop_dmag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_res_num        (rsp_res_num),
      .rsp_res_den        (rsp_res_den),
      .rsp_zero_den_error (rsp_zero_den_error)
   );

endmodule

`default_nettype wire

// ===== rtl/rar_front.sv =====
// rar_front: accepts a transaction, forms the cross products with one shared
// multiplier and classifies the raw fraction. Depends on rar_pkg.
`default_nettype none

module rar_front import rar_pkg::*; #(
   parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   output logic                        push_valid,
   input  logic                        push_full,
   output q_flags_type                 push_flags,
   output logic [2*OPERAND_BITS:0]     push_nmag,
   output logic [2*OPERAND_BITS-1:0]   push_dmag
);

   localparam int P  = OPERAND_BITS;
   localparam int DW = 2 * P;
   localparam int MW = 2 * P + 1;

   function automatic logic [P-1:0] mag_of(input logic [P-1:0] x);
      return x[P-1] ? (~x + P'(1)) : x;
   endfunction

   front_state_type state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [P-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic          san_ff, san_in, sad_ff, sad_in, sbn_ff, sbn_in, sbd_ff, sbd_in;
   logic [MW-1:0] num_ff, num_in;
   logic          num_neg_ff, num_neg_in;
   logic [DW-1:0] den_ff, den_in;
   logic          den_neg_ff, den_neg_in;
   logic [DW-1:0] p2_ff, p2_in;
   logic          p2_neg_ff, p2_neg_in;

   logic [P-1:0]  mul_x, mul_y;
   logic [DW-1:0] mul_p;
   logic [MW-1:0] p2_ext;
   logic          num_ge;

   assign mul_p  = DW'(mul_x) * DW'(mul_y);
   assign p2_ext = MW'(p2_ff);
   assign num_ge = (num_ff >= p2_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      san_ff     <= san_in;
      sad_ff     <= sad_in;
      sbn_ff     <= sbn_in;
      sbd_ff     <= sbd_in;
      num_ff     <= num_in;
      num_neg_ff <= num_neg_in;
      den_ff     <= den_in;
      den_neg_ff <= den_neg_in;
      p2_ff      <= p2_in;
      p2_neg_ff  <= p2_neg_in;
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      san_in     = san_ff;
      sad_in     = sad_ff;
      sbn_in     = sbn_ff;
      sbd_in     = sbd_ff;
      num_in     = num_ff;
      num_neg_in = num_neg_ff;
      den_in     = den_ff;
      den_neg_in = den_neg_ff;
      p2_in      = p2_ff;
      p2_neg_in  = p2_neg_ff;
      mul_x      = an_ff;
      mul_y      = bd_ff;
      req_stall  = 1'b1;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               kind_in  = req_kind;
               an_in    = mag_of(req_a_num);
               ad_in    = mag_of(req_a_den);
               bn_in    = mag_of(req_b_num);
               bd_in    = mag_of(req_b_den);
               san_in   = req_a_num[P-1];
               sad_in   = req_a_den[P-1];
               sbn_in   = req_b_num[P-1];
               sbd_in   = req_b_den[P-1];
               state_in = F_NUM;
            end
         end
         F_NUM: begin
            mul_x      = an_ff;
            mul_y      = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
            num_in     = MW'(mul_p);
            num_neg_in = san_ff ^ ((kind_ff == KIND_MUL) ? sbn_ff : sbd_ff);
            state_in   = F_DEN;
         end
         F_DEN: begin
            mul_x      = ad_ff;
            mul_y      = (kind_ff == KIND_DIV) ? bn_ff : bd_ff;
            den_in     = mul_p;
            den_neg_in = sad_ff ^ ((kind_ff == KIND_DIV) ? sbn_ff : sbd_ff);
            state_in   = (kind_ff == KIND_ADD || kind_ff == KIND_SUB) ? F_CROSS : F_PUSH;
         end
         F_CROSS: begin
            mul_x     = ad_ff;
            mul_y     = bn_ff;
            p2_in     = mul_p;
            p2_neg_in = sad_ff ^ sbn_ff ^ (kind_ff == KIND_SUB);
            state_in  = F_SUM;
         end
         F_SUM: begin
            // signed-magnitude add of the two cross products
            if (num_neg_ff == p2_neg_ff) begin
               num_in = num_ff + p2_ext;
            end else if (num_ge) begin
               num_in = num_ff - p2_ext;
            end else begin
               num_in     = p2_ext - num_ff;
               num_neg_in = p2_neg_ff;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (!push_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_flags.err  = (den_ff == '0);
   assign push_flags.zero = (num_ff == '0);
   assign push_flags.neg  = num_neg_ff ^ den_neg_ff;
   assign push_nmag       = num_ff;
   assign push_dmag       = den_ff;

endmodule

`default_nettype wire

// ===== rtl/rar_queue.sv =====
// rar_queue: short register FIFO between front and back.
// Depends on rar_pkg for its depth.
`default_nettype none

module rar_queue import rar_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_full,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_full  = (count_ff == CW'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && !wr_full;
   assign do_rd    = rd_pop && rd_valid;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rar_back.sv =====
// rar_back: reduces a queued fraction by binary GCD, divides both terms by
// it with a pair of restoring dividers and holds the result. Depends on rar_pkg.
`default_nettype none

module rar_back import rar_pkg::*; #(
   parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop,
   input  q_flags_type               pop_flags,
   input  logic [2*OPERAND_BITS:0]   pop_nmag,
   input  logic [2*OPERAND_BITS-1:0] pop_dmag,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [NUM_BITS-1:0] rsp_res_num,
   output logic [DEN_BITS-1:0]       rsp_res_den,
   output logic                      rsp_zero_den_error
);

   localparam int MW  = 2 * OPERAND_BITS + 1;
   localparam int CNW = $clog2(MW);
   localparam int XN  = (MW > NUM_BITS) ? MW : NUM_BITS;
   localparam int XD  = (MW > DEN_BITS) ? MW : DEN_BITS;

   back_state_type state_ff, state_in;
   q_flags_type    flags_ff, flags_in;
   logic [MW-1:0]  n_ff, n_in, d_ff, d_in, u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [MW-1:0]  rn_ff, rn_in, rd_ff, rd_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0]        den_ff, den_in;
   logic                       err_ff, err_in;

   logic [MW:0]   trial_n, trial_d;
   logic          ge_n, ge_d;
   logic [XN-1:0] n_wide, n_signed;
   logic [XD-1:0] d_wide;
   logic          can_load;

   assign trial_n  = {rn_ff, n_ff[MW-1]};
   assign trial_d  = {rd_ff, d_ff[MW-1]};
   assign ge_n     = (trial_n >= {1'b0, g_ff});
   assign ge_d     = (trial_d >= {1'b0, g_ff});
   assign n_wide   = XN'(n_ff);
   assign n_signed = flags_ff.neg ? (~n_wide + XN'(1)) : n_wide;
   assign d_wide   = XD'(d_ff);
   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      g_ff     <= g_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      err_ff   <= err_in;
   end

   always_comb begin
      state_in     = state_ff;
      flags_in     = flags_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               flags_in = pop_flags;
               n_in     = pop_nmag;
               d_in     = MW'(pop_dmag);
               state_in = (pop_flags.err || pop_flags.zero) ? B_DONE : B_STRIP;
            end
         end
         B_STRIP: begin
            // common powers of two come off both terms directly
            if (!n_ff[0] && !d_ff[0]) begin
               n_in = n_ff >> 1;
               d_in = d_ff >> 1;
            end else begin
               u_in     = n_ff;
               v_in     = d_ff;
               state_in = B_GCD;
            end
         end
         B_GCD: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff == v_ff) begin
               g_in     = u_ff;
               rn_in    = '0;
               rd_in    = '0;
               cnt_in   = '0;
               state_in = B_DIV;
            end else if (u_ff > v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         B_DIV: begin
            // one quotient bit per cycle for both terms; quotients shift into n/d
            rn_in  = ge_n ? MW'(trial_n - {1'b0, g_ff}) : MW'(trial_n);
            rd_in  = ge_d ? MW'(trial_d - {1'b0, g_ff}) : MW'(trial_d);
            n_in   = {n_ff[MW-2:0], ge_n};
            d_in   = {d_ff[MW-2:0], ge_d};
            cnt_in = cnt_ff + CNW'(1);
            if (cnt_ff == CNW'(MW - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (flags_ff.err) begin
                  num_in = '0;
                  den_in = '0;
                  err_in = 1'b1;
               end else if (flags_ff.zero) begin
                  num_in = '0;
                  den_in = DEN_BITS'(1);
                  err_in = 1'b0;
               end else begin
                  num_in = n_signed[NUM_BITS-1:0];
                  den_in = d_wide[DEN_BITS-1:0];
                  err_in = 1'b0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_num        = num_ff;
   assign rsp_res_den        = den_ff;
   assign rsp_zero_den_error = err_ff;

endmodule

`default_nettype wire

// ===== rtl/rar_checker.sv =====
// rar_checker: port-level checks on the result channel of the reducer.
// Depends on rar_pkg; bound to rational_arith_reduce below.
`default_nettype none

module rar_checker import rar_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [NUM_BITS-1:0] rsp_res_num,
   input logic [DEN_BITS-1:0]        rsp_res_den,
   input logic                       rsp_zero_den_error
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_num)
         && $stable(rsp_res_den) && $stable(rsp_zero_den_error))
      else $error("stalled transaction changed");

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_den_error |-> rsp_res_num == '0 && rsp_res_den == '0)
      else $error("error transaction carries nonzero fields");

   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_den_error |-> rsp_res_den != '0)
      else $error("zero denominator without error");

   a_zero_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_den_error && rsp_res_num == '0 |-> rsp_res_den == DEN_BITS'(1))
      else $error("zero result not 0/1");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);

`default_nettype wire
